// File: rtl/cgr_pkg.sv
// Shared types, constants and defaults for the clipped glyph rasterizer.
`timescale 1ns / 1ps

package cgr_pkg;

  // Default sizing
  localparam int DEF_MAX_GLYPH_WIDTH  = 16;
  localparam int DEF_MAX_GLYPH_HEIGHT = 16;
  localparam int DEF_FONT_BYTES       = 8192;

  // Span geometry: mask bits per span, font bytes fetched per row window
  localparam int MASK_W    = 16;
  localparam int WIN_BYTES = 3;
  localparam int WIN_W     = 8 * WIN_BYTES;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_CLIP_LEFT    = 3'd2,
    REG_CLIP_TOP     = 3'd3,
    REG_CLIP_RIGHT   = 3'd4,
    REG_CLIP_BOTTOM  = 3'd5,
    REG_DRAW_COLOR   = 3'd6
  } cgr_reg_t;

  // Input commands
  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_LOAD = 1'b1
  } cgr_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_ROW,
    ST_RD,
    ST_CAP,
    ST_EMIT
  } cgr_state_t;

endpackage

// File: rtl/clipped_glyph_rasterizer.sv
// Clipped bitmap-font glyph rasterizer: font store, row sequencer and span output.
// A load beat writes one font byte. A draw beat runs a small sequencer around
// one byte-wide font RAM port: setup states MUL (clamp, column mask and the
// width-by-height multiply) and BASE (the multiply for the glyph base bit), then
// per glyph row a ROW state to test the row against the clip, an RD and a CAP
// state per font byte fetched (one to three bytes, set by the row's bit offset
// and the glyph width up to 16), and an EMIT state for the span. Rows outside the
// clip, rows with no column in the clip and the underline row skip the fetch; the
// RAM port is the limit. in_stall is high for the whole draw; a finished span sits
// in the output register while the sequencer moves on, and the sequencer waits
// only when a second span is ready before the first was taken.
`timescale 1ns / 1ps

module clipped_glyph_rasterizer
  import cgr_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
  parameter int FONT_BYTES       = DEF_FONT_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [7:0]         in_char_code,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic               in_underline,
  input  logic [12:0]        in_font_address,
  input  logic [7:0]         in_font_data,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_row_y,
  output logic signed [15:0] out_row_x,
  output logic [15:0]        out_pixel_mask,
  output logic [23:0]        out_pixel_color,
  output logic               out_last_row
);

  localparam int DIM_W   = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int DIMH_W  = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int AW      = $clog2(FONT_BYTES);
  localparam int BIT_W   = $clog2(256 * MAX_GLYPH_WIDTH * MAX_GLYPH_HEIGHT + 64);
  localparam int BYTE_W  = BIT_W - 3;
  localparam int WH_W    = DIM_W + DIMH_W;

  // Configuration registers
  logic [4:0]         glyph_width_r, glyph_height_r;
  logic signed [15:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic [23:0]        draw_color_r;

  // Sequencer and datapath registers
  cgr_state_t          state_r, state_nxt;
  logic [DIM_W-1:0]    w_r, w_nxt;
  logic [DIMH_W-1:0]   h_r, h_nxt;
  logic [DIMH_W-1:0]   row_r, row_nxt;
  logic [WH_W-1:0]     wh_r, wh_nxt;
  logic [7:0]          code_r, code_nxt;
  logic signed [15:0]  x_r, x_nxt;
  logic signed [16:0]  ry_r, ry_nxt;
  logic                ul_r, ul_nxt;
  logic                ul_phase_r, ul_phase_nxt;
  logic [BIT_W-1:0]    rbit_r, rbit_nxt;
  logic [MASK_W-1:0]   colmask_r, colmask_nxt;
  logic [1:0]          bi_r, bi_nxt;
  logic [1:0]          lastb_r, lastb_nxt;
  logic                oob_r, oob_nxt;
  logic [WIN_W-1:0]    win_r, win_nxt;

  // Output registers
  logic                out_valid_r, out_valid_nxt;
  logic signed [16:0]  row_y_r, row_y_nxt;
  logic signed [15:0]  row_x_r, row_x_nxt;
  logic [15:0]         mask_r, mask_nxt;
  logic [23:0]         color_r, color_nxt;
  logic                last_r, last_nxt;

  // Combinational helpers
  logic               in_acc;
  logic               out_free;
  logic [DIM_W-1:0]   w_cl;
  logic [DIMH_W-1:0]  h_cl;
  logic signed [17:0] dl, dr;
  logic [MASK_W-1:0]  colmask_c;
  logic               row_in;
  logic               row_end;
  logic               span_last;
  logic [5:0]         cw6, span_end;
  logic [BYTE_W-1:0]  byte_idx;
  logic               byte_oob;
  logic [WIN_W-1:0]   win_sh;
  logic [4:0]         slot_lo;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         ram_rdata;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= 5'd8;
      glyph_height_r <= 5'd8;
      clip_left_r    <= 16'sd0;
      clip_top_r     <= 16'sd0;
      clip_right_r   <= 16'sd640;
      clip_bottom_r  <= 16'sd480;
      draw_color_r   <= 24'hFFFFFF;
    end else if (cfg_we) begin
      case (cgr_reg_t'(cfg_index))
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata[4:0];
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata[4:0];
        REG_CLIP_LEFT:    clip_left_r    <= cfg_wdata[15:0];
        REG_CLIP_TOP:     clip_top_r     <= cfg_wdata[15:0];
        REG_CLIP_RIGHT:   clip_right_r   <= cfg_wdata[15:0];
        REG_CLIP_BOTTOM:  clip_bottom_r  <= cfg_wdata[15:0];
        REG_DRAW_COLOR:   draw_color_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp glyph size into the supported range
  always_comb begin
    if (glyph_width_r == 5'd0) begin
      w_cl = DIM_W'(1);
    end else if (int'(glyph_width_r) > MAX_GLYPH_WIDTH) begin
      w_cl = DIM_W'(MAX_GLYPH_WIDTH);
    end else begin
      w_cl = DIM_W'(glyph_width_r);
    end
    if (glyph_height_r == 5'd0) begin
      h_cl = DIMH_W'(1);
    end else if (int'(glyph_height_r) > MAX_GLYPH_HEIGHT) begin
      h_cl = DIMH_W'(MAX_GLYPH_HEIGHT);
    end else begin
      h_cl = DIMH_W'(glyph_height_r);
    end
  end

  // Column mask: inside clip horizontally and within glyph width
  always_comb begin
    dl = {{2{clip_left_r[15]}}, clip_left_r} - {{2{x_r[15]}}, x_r};
    dr = {{2{clip_right_r[15]}}, clip_right_r} - {{2{x_r[15]}}, x_r};
    for (int c = 0; c < MASK_W; c++) begin
      colmask_c[c] = ($signed(18'(c)) >= dl) && ($signed(18'(c)) < dr) &&
                     (c < int'(w_cl));
    end
  end

  // Row tests and fetch window
  always_comb begin
    row_in    = (ry_r >= $signed({clip_top_r[15], clip_top_r})) &&
                (ry_r < $signed({clip_bottom_r[15], clip_bottom_r}));
    row_end   = (row_r == h_r - DIMH_W'(1));
    span_last = ul_phase_r || (!ul_r && row_end);
    cw6       = (int'(w_r) > MASK_W) ? 6'(MASK_W) : 6'(w_r);
    span_end  = 6'(rbit_r[2:0]) + cw6 - 6'd1;
    byte_idx  = rbit_r[BIT_W-1:3] + BYTE_W'(bi_r);
    byte_oob  = (32'(byte_idx) >= 32'(FONT_BYTES));
    win_sh    = win_r >> rbit_r[2:0];
    slot_lo   = {bi_r, 3'b000};
  end

  // Font RAM port: loads in idle, row fetches during a draw
  assign ram_we   = in_acc && (cgr_cmd_t'(in_command) == CMD_LOAD) &&
                    (32'(in_font_address) < 32'(FONT_BYTES));
  assign ram_addr = (state_r == ST_IDLE) ? AW'(in_font_address) : AW'(byte_idx);

  cgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_font_data),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (cgr_cmd_t'(in_command) == CMD_DRAW)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_ROW;
      ST_ROW: begin
        if (row_in && !ul_phase_r && (colmask_r != '0)) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_RD:  state_nxt = ST_CAP;
      ST_CAP: state_nxt = (bi_r == lastb_r) ? ST_EMIT : ST_RD;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = span_last ? ST_IDLE : ST_ROW;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    w_nxt         = w_r;
    h_nxt         = h_r;
    row_nxt       = row_r;
    wh_nxt        = wh_r;
    code_nxt      = code_r;
    x_nxt         = x_r;
    ry_nxt        = ry_r;
    ul_nxt        = ul_r;
    ul_phase_nxt  = ul_phase_r;
    rbit_nxt      = rbit_r;
    colmask_nxt   = colmask_r;
    bi_nxt        = bi_r;
    lastb_nxt     = lastb_r;
    oob_nxt       = oob_r;
    win_nxt       = win_r;
    row_y_nxt     = row_y_r;
    row_x_nxt     = row_x_r;
    mask_nxt      = mask_r;
    color_nxt     = color_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        // Capture the draw beat
        code_nxt = in_char_code;
        x_nxt    = in_pos_x;
        ry_nxt   = {in_pos_y[15], in_pos_y};
        ul_nxt   = in_underline;
      end
      ST_MUL: begin
        w_nxt       = w_cl;
        h_nxt       = h_cl;
        wh_nxt      = WH_W'(w_cl) * WH_W'(h_cl);
        colmask_nxt = colmask_c;
      end
      ST_BASE: begin
        rbit_nxt     = BIT_W'(code_r) * BIT_W'(wh_r);
        row_nxt      = '0;
        ul_phase_nxt = 1'b0;
      end
      ST_ROW: begin
        bi_nxt    = 2'd0;
        lastb_nxt = span_end[4:3];
      end
      ST_RD: begin
        oob_nxt = byte_oob;
      end
      ST_CAP: begin
        // Drop the fetched byte into its window slot
        win_nxt[slot_lo +: 8] = oob_r ? 8'h00 : ram_rdata;
        bi_nxt = bi_r + 2'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          row_y_nxt     = ry_r;
          row_x_nxt     = x_r;
          color_nxt     = draw_color_r;
          last_nxt      = span_last;
          if (!row_in) begin
            mask_nxt = '0;
          end else if (ul_phase_r) begin
            mask_nxt = colmask_r;
          end else begin
            mask_nxt = win_sh[MASK_W-1:0] & colmask_r;
          end
          // Advance to the next glyph row or the underline row
          ry_nxt = ry_r + 17'sd1;
          if (row_end) begin
            ul_phase_nxt = 1'b1;
          end else begin
            row_nxt  = row_r + DIMH_W'(1);
            rbit_nxt = rbit_r + BIT_W'(w_r);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    row_r      <= row_nxt;
    wh_r       <= wh_nxt;
    code_r     <= code_nxt;
    x_r        <= x_nxt;
    ry_r       <= ry_nxt;
    ul_r       <= ul_nxt;
    ul_phase_r <= ul_phase_nxt;
    rbit_r     <= rbit_nxt;
    colmask_r  <= colmask_nxt;
    bi_r       <= bi_nxt;
    lastb_r    <= lastb_nxt;
    oob_r      <= oob_nxt;
    win_r      <= win_nxt;
    row_y_r    <= row_y_nxt;
    row_x_r    <= row_x_nxt;
    mask_r     <= mask_nxt;
    color_r    <= color_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_row_y       = row_y_r;
  assign out_row_x       = row_x_r;
  assign out_pixel_mask  = mask_r;
  assign out_pixel_color = color_r;
  assign out_last_row    = last_r;

endmodule

// File: rtl/cgr_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module cgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read port every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the clipped glyph rasterizer: font loads, clipped spans.
`timescale 1ns / 1ps

module tb
  import cgr_pkg::*;
();

  localparam int TOTAL_ITEMS   = 430;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 4000;

  // One input beat: a font byte load or a glyph draw
  typedef struct {
    cgr_cmd_t          cmd;
    logic [7:0]        code;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic              ul;
    logic [12:0]       addr;
    logic [7:0]        data;
  } raster_cmd_t;

  // One output span
  typedef struct {
    logic signed [16:0] row_y;
    logic signed [15:0] row_x;
    logic [15:0]        mask;
    logic [23:0]        color;
    logic               last;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = 1'b0;
  logic [7:0]         in_char_code = '0;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic               in_underline = 1'b0;
  logic [12:0]        in_font_address = '0;
  logic [7:0]         in_font_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] out_row_y;
  logic signed [15:0] out_row_x;
  logic [15:0]        out_pixel_mask;
  logic [23:0]        out_pixel_color;
  logic               out_last_row;

  clipped_glyph_rasterizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_char_code    (in_char_code),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_underline    (in_underline),
    .in_font_address (in_font_address),
    .in_font_data    (in_font_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_y       (out_row_y),
    .out_row_x       (out_row_x),
    .out_pixel_mask  (out_pixel_mask),
    .out_pixel_color (out_pixel_color),
    .out_last_row    (out_last_row)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the block: registers and font bytes as of acceptance
  logic [4:0]  glyph_w = 5'd8;
  logic [4:0]  glyph_h = 5'd8;
  int          clip_l = 0;
  int          clip_t = 0;
  int          clip_r = 640;
  int          clip_b = 480;
  logic [23:0] draw_rgb = 24'hFFFFFF;
  logic [7:0]  font_bytes [DEF_FONT_BYTES];

  // Generation side: which font bytes have a load queued already
  bit          font_written [DEF_FONT_BYTES];

  raster_cmd_t pending_beats[$];
  span_t       expected_spans[$];
  raster_cmd_t cur_beat;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int items_queued = 0;
  int glyphs_drawn = 0;
  int font_loads = 0;
  int spans_checked = 0;
  int config_sets = 0;
  int quiet_cycles = 0;

  function automatic int sat_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Work out the spans of one draw and queue them
  function automatic void rasterize_glyph(raster_cmd_t b);
    int w, h, base, nrows, ry, px, bi;
    logic [15:0] mask;
    span_t s;
    w = sat_dim(int'(glyph_w), DEF_MAX_GLYPH_WIDTH);
    h = sat_dim(int'(glyph_h), DEF_MAX_GLYPH_HEIGHT);
    base = int'(b.code) * w * h;
    nrows = b.ul ? h + 1 : h;
    for (int r = 0; r < nrows; r++) begin
      ry = int'(b.y) + r;
      mask = '0;
      if (ry >= clip_t && ry < clip_b) begin
        for (int c = 0; c < w; c++) begin
          px = int'(b.x) + c;
          bi = base + r * w + c;
          // underline row is solid; glyph rows follow the font bits
          if (px >= clip_l && px < clip_r && (r == h || font_bytes[bi >> 3][bi & 7]))
            mask[c] = 1'b1;
        end
      end
      s.row_y = 17'(ry);
      s.row_x = b.x;
      s.mask  = mask;
      s.color = draw_rgb;
      s.last  = (r == nrows - 1);
      expected_spans.push_back(s);
    end
  endfunction

  // Input driver: predict on acceptance, then present the next beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (cur_beat.cmd == CMD_LOAD) begin
          font_bytes[cur_beat.addr] = cur_beat.data;
          font_loads++;
        end else begin
          rasterize_glyph(cur_beat);
          glyphs_drawn++;
        end
      end
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_beat = pending_beats.pop_front();
        in_valid        <= 1'b1;
        in_command      <= cur_beat.cmd;
        in_char_code    <= cur_beat.code;
        in_pos_x        <= cur_beat.x;
        in_pos_y        <= cur_beat.y;
        in_underline    <= cur_beat.ul;
        in_font_address <= cur_beat.addr;
        in_font_data    <= cur_beat.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic flag_field(string name, int want, int got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  // Result monitor: compare each accepted span with the oldest expectation
  always @(posedge clk) begin : span_check
    span_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          errors++;
          $display("%0t: span with none expected, row_y %0d row_x %0d mask %h",
                   $time, out_row_y, out_row_x, out_pixel_mask);
        end else begin
          want = expected_spans.pop_front();
          spans_checked++;
          if (out_row_y !== want.row_y)
            flag_field("row_y", int'(want.row_y), int'(out_row_y));
          if (out_row_x !== want.row_x)
            flag_field("row_x", int'(want.row_x), int'(out_row_x));
          if (out_pixel_mask !== want.mask)
            flag_field("pixel_mask", int'(want.mask), int'(out_pixel_mask));
          if (out_pixel_color !== want.color)
            flag_field("pixel_color", int'(want.color), int'(out_pixel_color));
          if (out_last_row !== want.last)
            flag_field("last_row", int'(want.last), int'(out_last_row));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("clipped_glyph_rasterizer: mismatch");
        $finish;
      end
    end
  end

  task automatic queue_load(int addr, int data);
    raster_cmd_t b;
    b.cmd  = CMD_LOAD;
    b.addr = 13'(addr);
    b.data = 8'(data);
    b.code = 8'($urandom());
    b.x    = 16'($urandom());
    b.y    = 16'($urandom());
    b.ul   = 1'($urandom());
    font_written[b.addr] = 1'b1;
    pending_beats.push_back(b);
    items_queued++;
  endtask

  // Queue a draw, preceded by loads for any glyph byte not yet written
  task automatic queue_draw(int code, int x, int y, int ul);
    int w, h, base, first_byte, last_byte;
    raster_cmd_t b;
    w = sat_dim(int'(glyph_w), DEF_MAX_GLYPH_WIDTH);
    h = sat_dim(int'(glyph_h), DEF_MAX_GLYPH_HEIGHT);
    base = (code & 255) * w * h;
    first_byte = base >> 3;
    last_byte = (base + w * h - 1) >> 3;
    for (int a = first_byte; a <= last_byte; a++)
      if (!font_written[a]) queue_load(a, $urandom_range(0, 255));
    b.cmd  = CMD_DRAW;
    b.code = 8'(code);
    b.x    = 16'(x);
    b.y    = 16'(y);
    b.ul   = 1'(ul);
    b.addr = 13'($urandom());
    b.data = 8'($urandom());
    pending_beats.push_back(b);
    items_queued++;
  endtask

  // Hold until every beat is taken and every span has come, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_spans.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cgr_reg_t idx, int val);
    logic signed [15:0] v16;
    v16 = 16'(val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 24'(val);
    case (idx)
      REG_GLYPH_WIDTH:  glyph_w = 5'(val);
      REG_GLYPH_HEIGHT: glyph_h = 5'(val);
      REG_CLIP_LEFT:    clip_l = v16;
      REG_CLIP_TOP:     clip_t = v16;
      REG_CLIP_RIGHT:   clip_r = v16;
      REG_CLIP_BOTTOM:  clip_b = v16;
      REG_DRAW_COLOR:   draw_rgb = 24'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int gw, int gh, int l, int t, int r, int bt, int color);
    wait_idle();
    write_reg(REG_GLYPH_WIDTH, gw);
    write_reg(REG_GLYPH_HEIGHT, gh);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, bt);
    write_reg(REG_DRAW_COLOR, color);
    @(negedge clk);
    config_sets++;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0:       begin send_idle_pct = 24; recv_idle_pct = 69; end
      1:       begin send_idle_pct = 69; recv_idle_pct = 24; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
  endtask

  // Mostly small glyphs, a few large ones up to the largest size, a few out of range
  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 31);
      1:       return $urandom_range(11, 16);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  initial begin : stimulus
    int directed_items, gw, gh, l, t, r, bt, color, x, y, code;
    set_idle(0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: corners, partial clip, far outside
    queue_load(0, 8'h00);
    queue_load(DEF_FONT_BYTES - 1, 8'hFF);
    queue_draw(0, 0, 0, 0);
    queue_draw(255, 632, 472, 1);
    queue_draw(65, -3, -2, 1);
    queue_draw(66, 636, 100, 0);
    queue_draw(67, -32768, -32768, 1);
    queue_draw(68, 32767, 32767, 0);

    // Largest glyph, widest clip, extreme positions
    set_config(16, 16, -32768, -32768, 32767, 32767, 0);
    queue_draw(255, 32767, 32767, 1);
    queue_draw(0, -32768, -32768, 1);
    queue_draw(1, -8, 32760, 1);

    // Zero size saturates up to one pixel
    set_config(0, 0, 0, 0, 640, 480, 24'hABCDEF);
    queue_draw(3, 0, 0, 1);
    queue_draw(255, 639, 479, 1);

    // Oversize saturates down; empty clip in x
    set_config(17, 31, 100, 0, 100, 480, 24'hFFFFFF);
    queue_draw(7, 90, 10, 1);

    // Inverted clip in y
    set_config(31, 3, 0, 50, 640, 40, 24'h00FF00);
    queue_draw(9, 0, 45, 1);

    directed_items = items_queued;

    // Random phases: new settings, then draws mostly near the clip edges and stray loads
    while (items_queued < TOTAL_ITEMS) begin
      set_idle((items_queued - directed_items) * 3 / (TOTAL_ITEMS - directed_items));
      gw = pick_dim();
      gh = pick_dim();
      color = $urandom_range(0, 24'hFFFFFF);
      case ($urandom_range(0, 9))
        0: begin
          l = $urandom_range(0, 65535);
          t = $urandom_range(0, 65535);
          r = $urandom_range(0, 65535);
          bt = $urandom_range(0, 65535);
        end
        1: begin
          l = int'($urandom_range(0, 200)) - 100;
          r = l - int'($urandom_range(0, 3));
          t = int'($urandom_range(0, 200)) - 100;
          bt = t + int'($urandom_range(0, 40));
        end
        default: begin
          l = int'($urandom_range(0, 120)) - 60;
          r = l + int'($urandom_range(0, 80));
          t = int'($urandom_range(0, 120)) - 60;
          bt = t + int'($urandom_range(0, 80));
        end
      endcase
      set_config(gw, gh, l, t, r, bt, color);
      repeat ($urandom_range(12, 30)) begin
        if ($urandom_range(0, 99) < 15) begin
          queue_load($urandom_range(0, DEF_FONT_BYTES - 1), $urandom_range(0, 255));
        end else begin
          if ($urandom_range(0, 9) == 0) begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
          end else begin
            x = ($urandom_range(0, 1) ? clip_l : clip_r) + int'($urandom_range(0, 40)) - 24;
            y = ($urandom_range(0, 1) ? clip_t : clip_b) + int'($urandom_range(0, 40)) - 24;
          end
          code = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
          queue_draw(code, x, y, $urandom_range(0, 1));
        end
      end
    end

    wait_idle();
    $display("covered %0d glyph draws and %0d font loads under %0d register settings",
             glyphs_drawn, font_loads, config_sets + 1);
    $display("checked %0d spans, %0d field errors", spans_checked, errors);
    if (errors == 0)
      $display("clipped_glyph_rasterizer: match");
    else
      $display("clipped_glyph_rasterizer: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/cgr_pkg.sv
rtl/cgr_ram.sv
rtl/clipped_glyph_rasterizer.sv
tb/tb.sv
